// ----- src/npcs_pkg.sv -----
// Package for the nearest palette color search block.
// Holds shared constants, the cell data word and the sequencer states; no dependencies.
`timescale 1ns / 1ps
package npcs_pkg;
	localparam int ENTRIES_DEF = 256;
	localparam int CH_W = 8;
	localparam int IDX_W = 8;
	localparam int DIST_W = 18;
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} state_t;
endpackage

// ----- src/nearest_palette_color_search.sv -----
// Top level of the nearest palette color search: a chain of ENTRIES cells plus a sequencer.
// Depends on npcs_pkg and npcs_cell.
//
//  channel | valid    | stall    | payload
//  input   | in_valid | in_stall | action, entry_index, red, green, blue
//  output  | out_valid| out_stall| nearest_index
//
// A write word is stored in the cell whose slot matches entry_index. A query word travels
// the chain one cell per cycle, through one register per cell; its result then waits for
// the consumer, and no new word is taken until the result is taken. Reset clears control
// only; palette words are undefined until written. in_stall is high while a query is in
// flight or its result is not yet taken.
`timescale 1ns / 1ps
module nearest_palette_color_search import npcs_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             action,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] nearest_index
);
	logic             vld [ENTRIES+1];
	rgb_t             qry [ENTRIES+1];
	logic [DIST_W-1:0] dst [ENTRIES+1];
	logic [IDX_W-1:0] idx [ENTRIES+1];
	state_t state_q, state_d;
	logic accept, wr_en;
	rgb_t in_color;
	logic [IDX_W-1:0] result_q;

	assign accept   = in_valid && !in_stall;
	assign wr_en    = accept && action == ACT_WRITE;
	assign in_color = '{red: red, green: green, blue: blue};

	// Launch the query word into the head of the chain
	assign vld[0] = accept && action == ACT_QUERY;
	assign qry[0] = in_color;
	assign dst[0] = '1;
	assign idx[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		npcs_cell #(.SLOT(i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.wr_en(wr_en), .wr_index(entry_index), .wr_color(in_color),
			.prev_valid(vld[i]), .prev_query(qry[i]), .prev_dist(dst[i]),
			.prev_index(idx[i]),
			.next_valid(vld[i+1]), .next_query(qry[i+1]), .next_dist(dst[i+1]),
			.next_index(idx[i+1])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (vld[0]) state_d = ST_SCAN;
			ST_SCAN: if (vld[ENTRIES]) state_d = ST_OUT;
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the answer word from the chain tail
	always_ff @(posedge clk) begin
		if (vld[ENTRIES]) begin
			result_q <= idx[ENTRIES];
		end
	end

	// Outputs
	always_comb begin
		in_stall  = state_q != ST_IDLE;
		out_valid = state_q == ST_OUT;
	end
	assign nearest_index = result_q;

	a_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] |=> state_q == ST_SCAN) else $error("query not tracked");
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld[ENTRIES] |-> state_q == ST_SCAN) else $error("stray chain word");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(nearest_index)) else $error("result changed");
endmodule

// ----- src/npcs_cell.sv -----
// One cell of the search chain: holds one palette word and compares it with the passing query.
// Depends on npcs_pkg.
`timescale 1ns / 1ps
module npcs_cell import npcs_pkg::*; #(
	parameter int SLOT = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  rgb_t                      wr_color,
	input  logic                      prev_valid,
	input  rgb_t                      prev_query,
	input  logic [DIST_W-1:0]         prev_dist,
	input  logic [IDX_W-1:0]          prev_index,
	output logic                      next_valid,
	output rgb_t                      next_query,
	output logic [DIST_W-1:0]         next_dist,
	output logic [IDX_W-1:0]          next_index
);
	rgb_t entry_q;
	logic [CH_W-1:0] dr, dg, db;
	logic [2*CH_W-1:0] sq_r, sq_g, sq_b;
	logic [DIST_W-1:0] cand_dist;
	logic valid_q;
	rgb_t query_q;
	logic [DIST_W-1:0] dist_q;
	logic [IDX_W-1:0] index_q;

	// Store this slot's entry on a matching write
	always_ff @(posedge clk) begin
		if (wr_en && ({{(32-IDX_W){1'b0}}, wr_index} == 32'(SLOT))) begin
			entry_q <= wr_color;
		end
	end

	// Distance between the stored entry and the query
	always_comb begin
		dr = (entry_q.red > prev_query.red) ? entry_q.red - prev_query.red
			: prev_query.red - entry_q.red;
		dg = (entry_q.green > prev_query.green) ? entry_q.green - prev_query.green
			: prev_query.green - entry_q.green;
		db = (entry_q.blue > prev_query.blue) ? entry_q.blue - prev_query.blue
			: prev_query.blue - entry_q.blue;
		sq_r = dr * dr;
		sq_g = dg * dg;
		sq_b = db * db;
		cand_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
	end

	// Advance the running minimum; the first cell always takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		query_q <= prev_query;
		if (SLOT == 0 || cand_dist < prev_dist) begin
			dist_q  <= cand_dist;
			index_q <= IDX_W'(SLOT);
		end else begin
			dist_q  <= prev_dist;
			index_q <= prev_index;
		end
	end

	assign next_valid = valid_q;
	assign next_query = query_q;
	assign next_dist  = dist_q;
	assign next_index = index_q;
endmodule
